// File: rtl/core/ssd_pkg.sv
// shared constants, types and the segment table for the seven-segment serial driver
// used by ssd_front, ssd_fifo, ssd_back and seven_segment_serial_driver_unit
// no dependencies
package ssd_pkg;

  // number of decimal digits shown, one byte each in the frame
  localparam int unsigned DIGITS     = 4;
  localparam int unsigned VALUE_W    = 14;
  localparam int unsigned IN_DATA_W  = ((VALUE_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned FRAME_BITS = 8 * DIGITS;
  localparam int unsigned CNT_W      = $clog2(FRAME_BITS);
  localparam int unsigned DIGIT_W    = 4;

  // divide by ten as multiply by reciprocal, exact for values below 43690
  localparam int unsigned RADIX       = 10;
  localparam int unsigned DIV10_MUL   = 52429;
  localparam int unsigned DIV10_MUL_W = 16;
  localparam int unsigned DIV10_SHIFT = 19;
  localparam int unsigned PROD_W      = VALUE_W + DIV10_MUL_W;
  localparam int unsigned QUOT_W      = PROD_W - DIV10_SHIFT;

  // frame queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [7:0]            seg_t;

  // active-high segment codes, bit 0 is segment a, dot always clear
  function automatic seg_t seg_code(input logic [DIGIT_W-1:0] digit);
    seg_t code;
    unique case (digit)
      4'd0:    code = 8'b0011_1111;
      4'd1:    code = 8'b0000_0110;
      4'd2:    code = 8'b0101_1011;
      4'd3:    code = 8'b0100_1111;
      4'd4:    code = 8'b0110_0110;
      4'd5:    code = 8'b0110_1101;
      4'd6:    code = 8'b0111_1101;
      4'd7:    code = 8'b0000_0111;
      4'd8:    code = 8'b0111_1111;
      4'd9:    code = 8'b0110_1111;
      default: code = 8'b0000_0000;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/core/seven_segment_serial_driver_unit.sv
// Seven-segment serial driver: number in, serial bit stream for a chain of
// segment shift registers out.
// Slave channel: one item per number, tdata[13:0] holds the value.
// Master channel: one item per frame bit, tdata[0] is the bit, tlast marks the
// final bit of the frame.
// Each number shows its four lowest decimal digits, thousands byte first, each
// byte MSB first, active-high segments a to g in bits 0 to 6, dot clear.
// A number passes the first digit stage and three more, then the queue, then
// the shift stage, whose register drives the first bit of its frame.
// The shift stage sends one bit per cycle while the receiver is ready and so
// sets the pace of numbers; when a frame waits in the queue, it follows its
// predecessor with no gap.
// A two-frame queue parts the digit pipeline from the shifter, so numbers are
// still taken while a frame is going out. When the receiver stalls, the
// current bit holds and the pipeline fills up before s_axis_tready drops.
// Reset empties the pipeline, the queue and the shifter; no item is pending.
// depends on ssd_pkg, ssd_front, ssd_fifo, ssd_back
module seven_segment_serial_driver_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ssd_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [13:0] value
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ssd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [0] serial_bit
  output logic                              m_axis_tlast    // last_bit
);

  logic            fr_valid, fr_ready;
  ssd_pkg::frame_t fr_frame;
  logic            bk_valid, bk_ready;
  ssd_pkg::frame_t bk_frame;
  logic            ser_bit;

  // digit extraction and segment lookup
  ssd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata[ssd_pkg::VALUE_W-1:0]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_frame_o (fr_frame)
  );

  // frame queue
  ssd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_frame_i  (fr_frame),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready),
    .out_frame_o (bk_frame)
  );

  // serial shifter
  ssd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .in_frame_i  (bk_frame),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_bit_o   (ser_bit),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(ssd_pkg::OUT_DATA_W-1){1'b0}}, ser_bit};

endmodule

// File: rtl/core/ssd_front.sv
// front part: takes numbers and peels off one decimal digit per pipeline stage
// builds the segment frame, least significant digit in the lowest byte
// depends on ssd_pkg
module ssd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ssd_pkg::VALUE_W-1:0]    in_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ssd_pkg::frame_t                out_frame_o
);

  logic [ssd_pkg::DIGITS-1:0]  vld_q, vld_d;
  logic [ssd_pkg::DIGITS:0]    rdy;
  logic [ssd_pkg::VALUE_W-1:0] num_q  [ssd_pkg::DIGITS];
  logic [ssd_pkg::VALUE_W-1:0] num_nx [ssd_pkg::DIGITS];
  ssd_pkg::frame_t             frm_q  [ssd_pkg::DIGITS];
  ssd_pkg::frame_t             frm_nx [ssd_pkg::DIGITS];

  // ready ripples back from the queue through each stage
  assign rdy[ssd_pkg::DIGITS] = out_ready_i;

  for (genvar i = 0; i < ssd_pkg::DIGITS; i++) begin : g_stage
    logic [ssd_pkg::PROD_W-1:0]  prod;
    logic [ssd_pkg::QUOT_W-1:0]  quot;
    logic [ssd_pkg::VALUE_W-1:0] rem;

    assign rdy[i] = !vld_q[i] || rdy[i+1];

    // one digit: quotient by reciprocal, remainder by back-multiply
    always_comb begin
      prod      = ssd_pkg::PROD_W'(num_q[i]) * ssd_pkg::PROD_W'(ssd_pkg::DIV10_MUL);
      quot      = prod[ssd_pkg::PROD_W-1:ssd_pkg::DIV10_SHIFT];
      rem       = num_q[i] - ssd_pkg::VALUE_W'(quot) * ssd_pkg::VALUE_W'(ssd_pkg::RADIX);
      num_nx[i] = ssd_pkg::VALUE_W'(quot);
      frm_nx[i] = frm_q[i];
      frm_nx[i][8*i +: 8] = ssd_pkg::seg_code(rem[ssd_pkg::DIGIT_W-1:0]);
    end

    // stage valid advances when the stage is free or drains
    always_comb begin
      vld_d[i] = vld_q[i];
      if (rdy[i]) begin
        if (i == 0) begin
          vld_d[i] = in_valid_i;
        end else begin
          vld_d[i] = vld_q[(i == 0) ? 0 : i-1];
        end
      end
    end

    // stage payload, loaded with the raw number at the first stage
    always_ff @(posedge clk_i) begin
      if (i == 0) begin
        if (in_valid_i && rdy[0]) begin
          num_q[i] <= in_value_i;
          frm_q[i] <= '0;
        end
      end else begin
        if (vld_q[(i == 0) ? 0 : i-1] && rdy[i]) begin
          num_q[i] <= num_nx[(i == 0) ? 0 : i-1];
          frm_q[i] <= frm_nx[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[ssd_pkg::DIGITS-1];
  assign out_frame_o = frm_nx[ssd_pkg::DIGITS-1];

endmodule

// File: rtl/core/ssd_fifo.sv
// short frame queue between the front and the back part
// depends on ssd_pkg
module ssd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ssd_pkg::frame_t in_frame_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ssd_pkg::frame_t out_frame_o
);

  ssd_pkg::frame_t                 mem_q [ssd_pkg::FIFO_DEPTH];
  logic [ssd_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [ssd_pkg::FIFO_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [ssd_pkg::FIFO_CNT_W-1:0]  cnt_q, cnt_d;
  logic                            push, pop;

  assign in_ready_o  = cnt_q != ssd_pkg::FIFO_CNT_W'(ssd_pkg::FIFO_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_frame_o = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + ssd_pkg::FIFO_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + ssd_pkg::FIFO_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + ssd_pkg::FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - ssd_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_frame_i;
    end
  end

endmodule

// File: rtl/core/ssd_back.sv
// back part: shifts each frame out one bit per item, most significant bit first
// the shift register doubles as the output register
// depends on ssd_pkg
module ssd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ssd_pkg::frame_t in_frame_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            out_bit_o,
  output logic            out_last_o
);

  ssd_pkg::frame_t           sh_q, sh_d;
  logic [ssd_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      vld_q, vld_d;
  logic                      is_last;
  logic                      take;

  assign is_last    = cnt_q == ssd_pkg::CNT_W'(ssd_pkg::FRAME_BITS - 1);
  assign take       = !vld_q || (out_ready_i && is_last);
  assign in_ready_o = take;

  // load a new frame when empty or when the last bit leaves, else shift while the receiver is ready
  always_comb begin
    vld_d = vld_q;
    cnt_d = cnt_q;
    sh_d  = sh_q;
    if (take) begin
      vld_d = in_valid_i;
      cnt_d = '0;
      sh_d  = in_frame_i;
    end else if (out_ready_i) begin
      cnt_d = cnt_q + ssd_pkg::CNT_W'(1);
      sh_d  = sh_q << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign out_valid_o = vld_q;
  assign out_bit_o   = sh_q[ssd_pkg::FRAME_BITS-1];
  assign out_last_o  = is_last;

endmodule
